>>> rtl/pcm_pkg.sv
// shared types and constants for the pulse capture measurement block
package pcm_pkg;

   // field widths
   localparam int CNT_W   = 16;
   localparam int PER_W   = 17;
   localparam int OVF_W   = 8;
   localparam int TICK_W  = 32;
   localparam int PSUM_W  = TICK_W + 1;
   localparam int FREQ_W  = 20;
   localparam int DUTY_W  = 14;
   localparam int DIST_W  = 37;
   localparam int MUL_W   = TICK_W + DUTY_W;
   localparam int STEP_W  = 5;

   // arithmetic constants
   localparam logic [FREQ_W-1:0] FREQ_NUM     = FREQ_W'(1000000);
   localparam logic [DUTY_W-1:0] DUTY_SCALE   = DUTY_W'(10000);
   localparam logic [PER_W-1:0]  PERIOD_RESET = PER_W'(100);

   // divider step counts, loaded as count minus one
   localparam logic [STEP_W-1:0] FREQ_LAST_STEP = STEP_W'(FREQ_W - 1);
   localparam logic [STEP_W-1:0] DUTY_LAST_STEP = STEP_W'(DUTY_W - 1);

   // item action codes
   localparam logic ACT_EDGE = 1'b0;
   localparam logic ACT_OVF  = 1'b1;

   // edge phase codes
   localparam logic [1:0] PH_FIRST = 2'd0;
   localparam logic [1:0] PH_FALL  = 2'd1;
   localparam logic [1:0] PH_NEXT  = 2'd2;

   // control states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } state_type;

   // input item
   typedef struct packed {
      logic              action;
      logic [CNT_W-1:0]  capture_count;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [TICK_W-1:0] high_ticks;
      logic [TICK_W-1:0] low_ticks;
      logic [FREQ_W-1:0] frequency_hz;
      logic [DUTY_W-1:0] duty_hundredths;
      logic [DIST_W-1:0] distance_milli_cm;
      logic              period_zero;
   } rsp_item_type;

endpackage

>>> rtl/pulse_capture_measure_core.sv
// pulse capture measurement core: edge timing, bit-serial frequency and duty division
//
// Usage: the req channel carries edge events (action 0, with the latched timer
// count) and timer overflow ticks (action 1). Edges cycle through first edge,
// falling edge and next rising edge; each overflow between edges adds counter_period
// timer counts to the span. On the closing rising edge one rsp item gives high and low
// ticks, frequency in Hz, duty in hundredths of a percent and echo distance.
// Flow: an overflow tick or a first edge is taken in the idle state; a falling
// edge also passes the span state; the closing rising edge passes accept, span, sum and
// multiply, then 20 + 14 steps of one shared restoring divider that produces
// one quotient bit per cycle, then the output state, which holds while stalled.
// A zero period skips the divider.
// Items are taken one at a time: req_stall is high while an item is in work
// and while a result is held. The result sits in an output register until
// rsp_stall is low. The csr port writes counter_period at any clock where
// csr_valid is high; csr_ready is always high.
// Reset (synchronous) sets counter_period to 100, clears edge phase, edge
// counts, overflow count and held high time, and returns to idle so no result is offered.
module pulse_capture_measure_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pcm_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pcm_pkg::rsp_item_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [16:0]           csr_data
);
   import pcm_pkg::*;

   state_type         state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  first_ff, first_in;
   logic [CNT_W-1:0]  second_ff, second_in;
   logic [OVF_W-1:0]  ovf_ff, ovf_in;
   logic [TICK_W-1:0] high_ff, high_in;
   logic [PER_W-1:0]  period_ff, period_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TICK_W-1:0] low_ff, low_in;
   logic [PSUM_W-1:0] psum_ff, psum_in;
   logic [MUL_W-1:0]  mul_ff, mul_in;
   logic [PSUM_W-1:0] rem_ff, rem_in;
   logic [FREQ_W-1:0] num_ff, num_in;
   logic [FREQ_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              duty_sel_ff, duty_sel_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   rsp_item_type      rsp_ff, rsp_in;

   logic              req_fire;
   logic [24:0]       extra;
   logic [CNT_W-1:0]  span_from;
   logic [TICK_W-1:0] span;
   logic [PSUM_W-1:0] psum;
   logic              psum_zero;
   logic [PSUM_W:0]   shifted;
   logic              take;
   logic              div_last;
   logic [DIST_W-1:0] echo_dist;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_data.action == ACT_EDGE &&
                (phase_ff == PH_FALL || phase_ff == PH_NEXT)) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: state_in = (phase_ff == PH_FALL) ? ST_IDLE : ST_PREP;
         ST_PREP: state_in = psum_zero ? ST_OUT : ST_DIV;
         ST_DIV:  state_in = div_last ? ST_OUT : ST_DIV;
         ST_OUT:  state_in = rsp_stall ? ST_OUT : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      csr_ready = 1'b1;
      rsp_data  = rsp_ff;
   end

   assign req_fire = req_valid && !req_stall;

   // edge span: count difference plus overflows times period, mod 2^32
   assign extra     = 25'(ovf_ff) * 25'(period_ff);
   assign span_from = (phase_ff == PH_FALL) ? first_ff : second_ff;
   assign span      = (TICK_W'(cnt_ff) - TICK_W'(span_from)) + TICK_W'(extra);

   // period sum and echo distance
   assign psum      = PSUM_W'(high_ff) + PSUM_W'(low_ff);
   assign psum_zero = (psum == '0);
   assign echo_dist = (DIST_W'(high_ff) << 4) + DIST_W'(high_ff);

   // one restoring divider step
   assign shifted  = {rem_ff, num_ff[FREQ_W-1]};
   assign take     = (shifted >= {1'b0, psum_ff});
   assign div_last = (step_ff == '0) && duty_sel_ff;

   // datapath next values
   always_comb begin
      phase_in    = phase_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      ovf_in      = ovf_ff;
      high_in     = high_ff;
      period_in   = period_ff;
      cnt_in      = cnt_ff;
      low_in      = low_ff;
      psum_in     = psum_ff;
      mul_in      = mul_ff;
      rem_in      = rem_ff;
      num_in      = num_ff;
      quo_in      = quo_ff;
      step_in     = step_ff;
      duty_sel_in = duty_sel_ff;
      freq_in     = freq_ff;
      rsp_in      = rsp_ff;

      // register write
      if (csr_valid && csr_ready) begin
         period_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.action == ACT_OVF) begin
                  ovf_in = ovf_ff + OVF_W'(1);
               end else if (phase_ff == PH_FALL || phase_ff == PH_NEXT) begin
                  cnt_in = req_data.capture_count;
               end else begin
                  first_in = req_data.capture_count;
                  ovf_in   = '0;
                  phase_in = PH_FALL;
               end
            end
         end
         ST_SPAN: begin
            ovf_in = '0;
            if (phase_ff == PH_FALL) begin
               second_in = cnt_ff;
               high_in   = span;
               phase_in  = PH_NEXT;
            end else begin
               low_in   = span;
               phase_in = PH_FIRST;
            end
         end
         ST_PREP: begin
            psum_in     = psum;
            mul_in      = MUL_W'(high_ff) * MUL_W'(DUTY_SCALE);
            rem_in      = '0;
            num_in      = FREQ_NUM;
            quo_in      = '0;
            step_in     = FREQ_LAST_STEP;
            duty_sel_in = 1'b0;
            rsp_in.high_ticks        = high_ff;
            rsp_in.low_ticks         = low_ff;
            rsp_in.frequency_hz      = '0;
            rsp_in.duty_hundredths   = '0;
            rsp_in.distance_milli_cm = echo_dist;
            rsp_in.period_zero       = psum_zero;
         end
         ST_DIV: begin
            quo_in  = {quo_ff[FREQ_W-2:0], take};
            rem_in  = take ? PSUM_W'(shifted - {1'b0, psum_ff}) : shifted[PSUM_W-1:0];
            num_in  = {num_ff[FREQ_W-2:0], 1'b0};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               if (duty_sel_ff) begin
                  rsp_in.frequency_hz    = freq_ff;
                  rsp_in.duty_hundredths = quo_in[DUTY_W-1:0];
               end else begin
                  // frequency done, seed duty division with the upper product bits
                  freq_in     = quo_in;
                  rem_in      = PSUM_W'(mul_ff[MUL_W-1:DUTY_W]);
                  num_in      = {mul_ff[DUTY_W-1:0], (FREQ_W-DUTY_W)'(0)};
                  quo_in      = '0;
                  step_in     = DUTY_LAST_STEP;
                  duty_sel_in = 1'b1;
               end
            end
         end
         ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_FIRST;
         first_ff  <= '0;
         second_ff <= '0;
         ovf_ff    <= '0;
         high_ff   <= '0;
         period_ff <= PERIOD_RESET;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         ovf_ff    <= ovf_in;
         high_ff   <= high_in;
         period_ff <= period_in;
      end
   end

   // payload and divider registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      low_ff      <= low_in;
      psum_ff     <= psum_in;
      mul_ff      <= mul_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      duty_sel_ff <= duty_sel_in;
      freq_ff     <= freq_in;
      rsp_ff      <= rsp_in;
   end

endmodule

>>> dv/pulse_capture_measure_core_test.sv
// self-checking testbench for the pulse capture measurement core
module pulse_capture_measure_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pcm_pkg::*;

   localparam int CLK_PERIOD    = 2;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES   = 400;
   localparam int STUCK_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 100;

   localparam longint unsigned FREQ_NUMERATOR = 1000000;
   localparam longint unsigned DUTY_FACTOR    = 10000;
   localparam longint unsigned DIST_FACTOR    = 17;

   // directed table row kinds
   typedef enum logic {
      ROW_ITEM,
      ROW_CFG
   } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic             action;
      logic [16:0]      value;
      logic             typed;
      rsp_item_type     result;
   } stim_row_type;

   // results that can be read straight off the definition
   localparam rsp_item_type NO_RESULT = '0;
   localparam rsp_item_type ZERO_PERIOD_RESULT =
      '{32'd0, 32'd0, 20'd0, 14'd0, 37'd0, 1'b1};
   localparam rsp_item_type ONE_OVF_RESULT =
      '{32'd100, 32'd0, 20'd10000, 14'd10000, 37'd1700, 1'b0};
   localparam rsp_item_type SHORTEST_RESULT =
      '{32'd1, 32'd0, 20'd1000000, 14'd10000, 37'd17, 1'b0};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [16:0]  csr_data = '0;

   // measurement predictor state
   logic [16:0]  meas_period = PER_W'(100);
   logic [1:0]   meas_phase = PH_FIRST;
   logic [15:0]  meas_first = '0;
   logic [15:0]  meas_second = '0;
   logic [7:0]   meas_overflows = '0;
   logic [31:0]  meas_high = '0;

   rsp_item_type expected_measurements[$];
   rsp_item_type oldest_measurement;

   int unsigned  sender_idle_pct = 0;
   int unsigned  receiver_stall_pct = 0;
   bit           receiver_hold = 1'b0;
   int unsigned  hold_count = 0;
   int unsigned  stuck_cycles = 0;
   int unsigned  items_sent = 0;
   int unsigned  results_checked = 0;
   int unsigned  period_writes = 0;
   int unsigned  error_count = 0;

   stim_row_type directed_rows [29] = '{
      '{ROW_ITEM, ACT_EDGE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd0,      1'b1, ZERO_PERIOD_RESULT},
      '{ROW_ITEM, ACT_OVF,  17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_OVF,  17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd0,      1'b1, ONE_OVF_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd1,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd1,      1'b1, SHORTEST_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd65535,  1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd65535,  1'b0, NO_RESULT},
      '{ROW_CFG,  ACT_EDGE, 17'd131071, 1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_OVF,  17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_CFG,  ACT_EDGE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd5,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_OVF,  17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd5,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd5,      1'b1, ZERO_PERIOD_RESULT},
      '{ROW_CFG,  ACT_EDGE, 17'd65536,  1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd100,    1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_OVF,  17'd0,      1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd50,     1'b0, NO_RESULT},
      '{ROW_ITEM, ACT_EDGE, 17'd200,    1'b0, NO_RESULT}
   };

   pulse_capture_measure_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // free-running clock
   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic bit chance(input int unsigned pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   // ticks from an earlier edge count to a later one, overflows included, modulo 2^32
   function automatic logic [31:0] span_ticks(input logic [15:0] from, input logic [15:0] to);
      return (32'(to) - 32'(from)) + 32'(meas_overflows) * 32'(meas_period);
   endfunction

   // advance the measurement state by one item; returns 1 when a result comes out
   function automatic bit predict_measurement(input req_item_type it,
                                              output rsp_item_type res);
      logic [31:0] low_t;
      logic [32:0] sum_t;
      bit          produced;
      res = '0;
      produced = 1'b0;
      if (it.action == ACT_OVF) begin
         meas_overflows = meas_overflows + 8'd1;
      end else begin
         case (meas_phase)
            PH_FALL: begin
               meas_second = it.capture_count;
               meas_high = span_ticks(meas_first, meas_second);
               meas_overflows = '0;
               meas_phase = PH_NEXT;
            end
            PH_NEXT: begin
               low_t = span_ticks(meas_second, it.capture_count);
               sum_t = {1'b0, meas_high} + {1'b0, low_t};
               res.high_ticks = meas_high;
               res.low_ticks = low_t;
               res.distance_milli_cm = DIST_W'(64'(meas_high) * DIST_FACTOR);
               res.period_zero = (sum_t == '0);
               // zero period leaves frequency and duty at zero
               if (sum_t != '0) begin
                  res.frequency_hz = FREQ_W'(FREQ_NUMERATOR / 64'(sum_t));
                  res.duty_hundredths = DUTY_W'((64'(meas_high) * DUTY_FACTOR) / 64'(sum_t));
               end
               meas_overflows = '0;
               meas_phase = PH_FIRST;
               produced = 1'b1;
            end
            default: begin
               meas_first = it.capture_count;
               meas_overflows = '0;
               meas_phase = PH_FALL;
            end
         endcase
      end
      return produced;
   endfunction

   // offer one item, holding it until the block takes it
   task automatic offer_item(input req_item_type it, input bit typed = 1'b0,
                             input rsp_item_type typed_res = '0);
      rsp_item_type res;
      while (chance(sender_idle_pct)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (predict_measurement(it, res))
         expected_measurements.push_back(typed ? typed_res : res);
   endtask

   // write counter_period once the block has gone quiet
   task automatic write_period(input logic [16:0] value);
      req_valid <= 1'b0;
      while (expected_measurements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      meas_period = value;
      period_writes++;
   endtask

   function automatic logic [15:0] pick_count(input logic [15:0] prev);
      case ($urandom_range(9, 0))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return prev;
         3: return prev + 16'($urandom_range(3, 0));
         default: return 16'($urandom());
      endcase
   endfunction

   // overflow ticks between consecutive edges, now and then a run past the 8-bit wrap
   function automatic int unsigned overflow_gap();
      int unsigned r;
      r = $urandom_range(99, 0);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 99) return $urandom_range(20, 4);
      return $urandom_range(300, 250);
   endfunction

   // mostly full first, falling and closing edge measurements, with stray items that can shift the phase
   task automatic run_random_phase(input int unsigned item_goal, input bit force_wrap);
      int unsigned first_item;
      int unsigned gap;
      logic [15:0] last_count;
      bit          wrap_left;
      first_item = items_sent;
      last_count = '0;
      wrap_left = force_wrap;
      while (items_sent - first_item < item_goal) begin
         if (chance(5))
            offer_item(req_item_type'{logic'($urandom_range(1, 0)), 16'($urandom())});
         for (int e = 0; e < 3; e++) begin
            gap = overflow_gap();
            if (wrap_left && e == 1) begin
               gap = 256 + $urandom_range(20, 0);
               wrap_left = 1'b0;
            end
            repeat (gap) offer_item(req_item_type'{ACT_OVF, 16'($urandom())});
            last_count = pick_count(last_count);
            offer_item(req_item_type'{ACT_EDGE, last_count});
         end
      end
   endtask

   task automatic run_phase(input logic [16:0] period, input int unsigned send_pct,
                            input int unsigned recv_pct, input bit hold,
                            input bit force_wrap);
      write_period(period);
      sender_idle_pct = send_pct;
      receiver_stall_pct = recv_pct;
      receiver_hold = hold;
      run_random_phase(PHASE_ITEMS, force_wrap);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // result side: compare each taken item, then choose the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_measurements.size() == 0) begin
            $error("result item with no measurement pending");
            error_count++;
         end else begin
            oldest_measurement = expected_measurements.pop_front();
            check_field("high_ticks", oldest_measurement.high_ticks, rsp_data.high_ticks);
            check_field("low_ticks", oldest_measurement.low_ticks, rsp_data.low_ticks);
            check_field("frequency_hz", oldest_measurement.frequency_hz,
                        rsp_data.frequency_hz);
            check_field("duty_hundredths", oldest_measurement.duty_hundredths,
                        rsp_data.duty_hundredths);
            check_field("distance_milli_cm", oldest_measurement.distance_milli_cm,
                        rsp_data.distance_milli_cm);
            check_field("period_zero", oldest_measurement.period_zero,
                        rsp_data.period_zero);
            results_checked++;
         end
      end
      // long hold-off so the block backs up into its input
      if (receiver_hold) begin
         if (hold_count < HOLD_CYCLES) begin
            hold_count++;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end else begin
         hold_count = 0;
         rsp_stall <= chance(receiver_stall_pct);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("pulse_capture_measure_core_test failed");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < $size(directed_rows); i++) begin
         if (directed_rows[i].kind == ROW_CFG)
            write_period(directed_rows[i].value);
         else
            offer_item(req_item_type'{directed_rows[i].action, directed_rows[i].value[15:0]},
                       directed_rows[i].typed, directed_rows[i].result);
      end

      // random phases over idling patterns and period settings
      run_phase(17'd65536, 0, 0, 1'b0, 1'b1);
      run_phase(17'd1, 81, 0, 1'b0, 1'b0);
      run_phase(17'($urandom_range(65536, 1)), 0, 81, 1'b0, 1'b0);
      run_phase(17'd0, 6, 6, 1'b0, 1'b0);
      run_phase(17'd131071, 0, 0, 1'b1, 1'b0);
      run_phase(17'($urandom_range(131071, 0)), 6, 6, 1'b0, 1'b0);

      // drain
      req_valid <= 1'b0;
      while (expected_measurements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d items (edges and overflow ticks) over %0d period settings,",
               items_sent, period_writes);
      $display("with %0d measurements compared field by field", results_checked);
      if (error_count == 0)
         $display("pulse_capture_measure_core_test passed");
      else
         $display("pulse_capture_measure_core_test failed");
      $finish;
   end

endmodule
